@@ rtl/ddo_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Odometry package
// Shared constants, types and the arctangent table of the odometry core.
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned TableLen    = 24;
  localparam int unsigned StepW       = $clog2(TableLen);

  localparam logic [50:0] TwoPiQ48   = 51'h6487ED5110B46;
  localparam logic [50:0] PiQ48      = 51'h3243F6A8885A3;
  localparam logic signed [33:0] PiQ30     = 34'sh0C90FDAA2;
  localparam logic signed [33:0] HalfPiQ30 = 34'sh06487ED51;
  localparam logic signed [33:0] GainQ30   = 34'sh026DD3B6A;

  localparam logic RegInchesPerDegree = 1'b0;
  localparam logic RegInverseTrack    = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MEAN, ST_COEF, ST_HEAD, ST_FIX, ST_CORDIC, ST_MULT, ST_ACC, ST_OUT
  } ddo_state_e;

  function automatic logic [29:0] atan_q30(input logic [StepW-1:0] i);
    case (i)
      5'd0:  atan_q30 = 30'h3243F6A8;
      5'd1:  atan_q30 = 30'h1DAC6705;
      5'd2:  atan_q30 = 30'h0FADBAFC;
      5'd3:  atan_q30 = 30'h07F56EA6;
      5'd4:  atan_q30 = 30'h03FEAB76;
      5'd5:  atan_q30 = 30'h01FFD55B;
      5'd6:  atan_q30 = 30'h00FFFAAA;
      5'd7:  atan_q30 = 30'h007FFF55;
      5'd8:  atan_q30 = 30'h003FFFEA;
      5'd9:  atan_q30 = 30'h001FFFFD;
      5'd10: atan_q30 = 30'h000FFFFF;
      5'd11: atan_q30 = 30'h0007FFFF;
      5'd12: atan_q30 = 30'h0003FFFF;
      5'd13: atan_q30 = 30'h0001FFFF;
      5'd14: atan_q30 = 30'h0000FFFF;
      5'd15: atan_q30 = 30'h00007FFF;
      5'd16: atan_q30 = 30'h00003FFF;
      5'd17: atan_q30 = 30'h00001FFF;
      5'd18: atan_q30 = 30'h00000FFF;
      5'd19: atan_q30 = 30'h000007FF;
      5'd20: atan_q30 = 30'h000003FF;
      5'd21: atan_q30 = 30'h000001FF;
      5'd22: atan_q30 = 30'h000000FF;
      5'd23: atan_q30 = 30'h0000007F;
      default: atan_q30 = '0;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ rtl/ddo_serial_mul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Serial multiplier
// Unsigned shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ddo_serial_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] a_i,
  input  logic [32:0] b_i,
  output logic        done_o,
  output logic [65:0] p_o
);
  logic [65:0] acc_q, acc_d;
  logic [32:0] a_q, a_d, b_q, b_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [66:0] sum;

  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    sum    = '0;
    if (start_i) begin
      acc_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      cnt_d  = 6'd33;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // take one multiplier bit, LSB first; add at the top, then shift down
      sum   = {1'b0, acc_q} + (b_q[0] ? {1'b0, a_q, 33'd0} : 67'd0);
      acc_d = sum[66:1];
      b_d   = {1'b0, b_q[32:1]};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  // full product after 33 steps
  assign p_o    = acc_q;
  assign done_o = done_q;

  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != 6'd0) else $error("mul busy with zero count");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("mul done while busy");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("mul did not start");
endmodule
`default_nettype wire

@@ rtl/ddo_cordic.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// CORDIC rotator
// Sine and cosine in Q.30, one rotation per cycle.
// ----------------------------------------------------------------------------
module ddo_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [33:0] angle_i,
  output logic               done_o,
  output logic signed [33:0] sin_o,
  output logic signed [33:0] cos_o
);
  import ddo_pkg::*;

  logic signed [33:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic               flip_q, flip_d, busy_q, busy_d, done_q, done_d;
  logic [StepW-1:0]   i_q, i_d;
  logic signed [33:0] xs, ys, at;

  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;
  assign at = $signed({4'd0, atan_q30(i_q)});

  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; flip_d = flip_q;
    i_d = i_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      x_d = GainQ30;
      y_d = '0;
      i_d = '0;
      busy_d = 1'b1;
      if (angle_i > HalfPiQ30) begin
        z_d = angle_i - PiQ30; flip_d = 1'b1;
      end else if (angle_i < -HalfPiQ30) begin
        z_d = angle_i + PiQ30; flip_d = 1'b1;
      end else begin
        z_d = angle_i; flip_d = 1'b0;
      end
    end else if (busy_q) begin
      if (!z_q[33]) begin
        x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - at;
      end else begin
        x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + at;
      end
      i_d = i_q + 1'b1;
      if (i_q == StepW'(CordicSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      i_q    <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d; flip_q <= flip_d;
  end

  assign sin_o  = flip_q ? -y_q : y_q;
  assign cos_o  = flip_q ? -x_q : x_q;
  assign done_o = done_q;

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> i_q < StepW'(CordicSteps)) else $error("cordic step overrun");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("cordic done while busy");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("cordic did not start");
endmodule
`default_nettype wire

@@ rtl/ddo_heading.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Heading reducer
// Bit-serial multiply of degree difference by the coefficient, modulo 2*pi.
// ----------------------------------------------------------------------------
module ddo_heading (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [32:0] ddeg_i,
  input  logic [47:0]        coef_i,
  output logic               done_o,
  output logic signed [51:0] head_o
);
  import ddo_pkg::*;

  logic [50:0] r_q, r_d, c_q, c_d;
  logic [32:0] mag_q, mag_d;
  logic        neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [51:0] t1, t2, fin;

  always_comb begin
    r_d = r_q; c_d = c_q; mag_d = mag_q; neg_d = neg_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    t1 = '0; t2 = '0;
    if (start_i) begin
      r_d    = '0;
      c_d    = {3'd0, coef_i};
      neg_d  = ddeg_i[32];
      mag_d  = ddeg_i[32] ? 33'(-ddeg_i) : 33'(ddeg_i);
      cnt_d  = 6'd33;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // double, then add coefficient when this magnitude bit is set
      t1 = {r_q, 1'b0};
      if (t1 >= {1'b0, TwoPiQ48}) t1 = t1 - {1'b0, TwoPiQ48};
      t2 = mag_q[32] ? t1 + {1'b0, c_q} : t1;
      if (t2 >= {1'b0, TwoPiQ48}) t2 = t2 - {1'b0, TwoPiQ48};
      r_d   = t2[50:0];
      mag_d = {mag_q[31:0], 1'b0};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d; c_q <= c_d; mag_q <= mag_d; neg_q <= neg_d;
  end

  always_comb begin
    fin = (neg_q && r_q != '0) ? {1'b0, TwoPiQ48 - r_q} : {1'b0, r_q};
    if (fin >= {1'b0, PiQ48}) fin = fin - {1'b0, TwoPiQ48};
  end

  assign head_o = $signed(fin);
  assign done_o = done_q;

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> r_q < TwoPiQ48) else $error("heading remainder out of range");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("heading done while busy");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("heading did not start");
endmodule
`default_nettype wire

@@ rtl/differential_drive_odometry_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Differential-drive odometry core
// Encoder samples in, saturating X/Y position and heading out.
// ----------------------------------------------------------------------------
// One item at a time: a sample occupies the core from its acceptance until
// the next item can be taken. It runs four serial multiplies (mean, heading
// coefficient, X delta, Y delta) of 33 steps each, a 33-step bit-serial
// modulo reduction, CordicSteps rotations, and the control states for accept,
// CORDIC start, the two accumulates and output; the bit-serial units take
// most of the time. A reset item clears the accumulators and goes straight
// to output. A new item is taken while the previous result waits in the
// output register; the next result is held until that one leaves. Configure
// only while idle with no result waiting.
module differential_drive_odometry_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                operation_i,
  input  logic signed [31:0]  left_degrees_i,
  input  logic signed [31:0]  right_degrees_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  x_position_o,
  output logic signed [31:0]  y_position_o,
  output logic signed [18:0]  heading_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [23:0]         cfg_data_i
);
  import ddo_pkg::*;

  ddo_state_e state_q, state_d;

  logic [23:0] ipd_q, itr_q;
  logic signed [31:0] prev_q, prev_d, xacc_q, xacc_d, yacc_q, yacc_d;
  logic signed [31:0] left_q, right_q;
  logic signed [32:0] delta_q, delta_d;
  logic signed [51:0] h48_q, h48_d;
  logic signed [33:0] sin_q, sin_d, cos_q, cos_d;
  logic signed [31:0] xo_q, xo_d, yo_q, yo_d;
  logic signed [18:0] ho_q, ho_d;
  logic        ov_q, ov_d;
  logic        phase_q, phase_d;
  logic signed [65:0] dx_q, dx_d;

  // shared serial multiplier
  logic        mul_start, mul_done;
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_p;
  logic        neg_a, neg_b;

  ddo_serial_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .p_o(mul_p)
  );

  logic hd_start, hd_done;
  logic signed [51:0] hd_out;
  logic signed [32:0] ddeg;

  // the coefficient product is still held by the multiplier at start
  ddo_heading u_head (
    .clk_i, .rst_ni, .start_i(hd_start), .ddeg_i(ddeg), .coef_i(mul_p[47:0]),
    .done_o(hd_done), .head_o(hd_out)
  );

  logic cr_start, cr_done;
  logic signed [33:0] cr_sin, cr_cos;

  ddo_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(cr_start), .angle_i(34'(h48_q >>> 18)),
    .done_o(cr_done), .sin_o(cr_sin), .cos_o(cr_cos)
  );

  assign ddeg = 33'(left_q) - 33'(right_q);

  // mean, sign-magnitude multiply: (l+r) * ipd
  logic signed [32:0] lr_sum, in_sum;
  logic [32:0]        in_mag;
  assign lr_sum = 33'(left_q) + 33'(right_q);
  assign in_sum = 33'(left_degrees_i) + 33'(right_degrees_i);
  assign in_mag = in_sum[32] ? 33'(-in_sum) : 33'(in_sum);

  // trig operands: Q.28 sine/cosine times delta
  logic signed [33:0] trig_op, sin_next, cos_next;
  logic [32:0]        dlt_mag, sin_next_mag, cos_next_mag;
  assign trig_op      = phase_q ? (cos_q >>> 2) : (sin_q >>> 2);
  assign dlt_mag      = delta_q[32] ? 33'(-delta_q) : 33'(delta_q);
  assign sin_next     = cr_sin >>> 2;
  assign sin_next_mag = sin_next[33] ? 33'(-sin_next) : 33'(sin_next);
  assign cos_next     = cos_q >>> 2;
  assign cos_next_mag = cos_next[33] ? 33'(-cos_next) : 33'(cos_next);

  logic signed [66:0] sprod;
  logic signed [66:0] mean_full;
  logic signed [57:0] mean_sh;
  logic signed [34:0] acc_sum;
  logic signed [31:0] mean_sat, acc_sat, acc_cur;

  assign sprod = (neg_a ^ neg_b) ? -$signed({1'b0, mul_p}) : $signed({1'b0, mul_p});

  always_comb begin
    mean_full = sprod;
    mean_sh   = 58'(mean_full >>> 9);
    if (mean_sh > 58'sd2147483647)       mean_sat = 32'sh7FFFFFFF;
    else if (mean_sh < -58'sd2147483648) mean_sat = 32'sh80000000;
    else                                  mean_sat = mean_sh[31:0];
    acc_cur = phase_q ? yacc_q : xacc_q;
    acc_sum = 35'(acc_cur) + 35'(dx_q >>> 28);
    if (acc_sum > 35'sd2147483647)       acc_sat = 32'sh7FFFFFFF;
    else if (acc_sum < -35'sd2147483648) acc_sat = 32'sh80000000;
    else                                  acc_sat = acc_sum[31:0];
  end

  always_comb begin
    state_d = state_q;
    prev_d = prev_q; xacc_d = xacc_q; yacc_d = yacc_q;
    delta_d = delta_q; h48_d = h48_q; sin_d = sin_q; cos_d = cos_q;
    xo_d = xo_q; yo_d = yo_q; ho_d = ho_q; ov_d = ov_q; phase_d = phase_q;
    dx_d = dx_q;
    mul_start = 1'b0; mul_a = '0; mul_b = '0;
    neg_a = 1'b0; neg_b = 1'b0;
    hd_start = 1'b0; cr_start = 1'b0;
    in_ready_o = 1'b0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (operation_i) begin
            prev_d = '0; xacc_d = '0; yacc_d = '0;
            state_d = ST_OUT;
          end else begin
            state_d = ST_MEAN;
            mul_start = 1'b1;
            mul_a = in_mag; mul_b = {9'd0, ipd_q};
          end
        end
      end
      ST_MEAN: begin
        neg_a = lr_sum[32];
        if (mul_done) begin
          delta_d = 33'(mean_sat) - 33'(prev_q);
          prev_d  = mean_sat;
          mul_start = 1'b1;
          mul_a = {9'd0, ipd_q}; mul_b = {9'd0, itr_q};
          state_d = ST_COEF;
        end
      end
      ST_COEF: begin
        if (mul_done) begin
          hd_start = 1'b1;
          state_d = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (hd_done) begin
          h48_d = hd_out;
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        cr_start = 1'b1;
        state_d = ST_CORDIC;
      end
      ST_CORDIC: begin
        if (cr_done) begin
          sin_d = cr_sin; cos_d = cr_cos;
          phase_d = 1'b0;
          state_d = ST_MULT;
          mul_start = 1'b1;
          mul_a = sin_next_mag; mul_b = dlt_mag;
        end
      end
      ST_MULT: begin
        neg_a = trig_op[33]; neg_b = delta_q[32];
        if (mul_done) begin
          dx_d = sprod[65:0];
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        if (phase_q) begin
          yacc_d = acc_sat;
          state_d = ST_OUT;
        end else begin
          xacc_d = acc_sat;
          phase_d = 1'b1;
          mul_start = 1'b1;
          mul_a = cos_next_mag; mul_b = dlt_mag;
          state_d = ST_MULT;
        end
      end
      ST_OUT: begin
        // hold until the previous result has left
        if (!ov_q || out_ready_i) begin
          xo_d = xacc_q; yo_d = yacc_q;
          ho_d = (prev_q == '0 && xacc_q == '0 && yacc_q == '0 && h48_q == '0)
                 ? '0 : 19'(h48_q >>> 32);
          ov_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign cfg_ready_o = (state_q == ST_IDLE) && !ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
      ipd_q   <= 24'd402653;
      itr_q   <= 24'd3050402;
      prev_q  <= '0;
      xacc_q  <= '0;
      yacc_q  <= '0;
      h48_q   <= '0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      prev_q  <= prev_d;
      xacc_q  <= xacc_d;
      yacc_q  <= yacc_d;
      h48_q   <= (state_q == ST_IDLE && in_valid_i && operation_i) ? '0 : h48_d;
      phase_q <= phase_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == RegInchesPerDegree) ipd_q <= cfg_data_i;
        else                                   itr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      left_q  <= left_degrees_i;
      right_q <= right_degrees_i;
    end
    delta_q <= delta_d; sin_q <= sin_d; cos_q <= cos_d;
    xo_q <= xo_d; yo_q <= yo_d; ho_q <= ho_d; dx_q <= dx_d;
  end

  assign out_valid_o  = ov_q;
  assign x_position_o = xo_q;
  assign y_position_o = yo_q;
  assign heading_o    = ho_q;

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> (ov_q && $stable(xo_q) && $stable(yo_q) && $stable(ho_q)))
    else $error("result overwritten");
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE) else $error("ready while busy");
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (ho_q >= -19'sd205888 && ho_q <= 19'sd205887))
    else $error("heading out of range");
endmodule
`default_nettype wire
